>>> rtl/csp_pkg.sv
`timescale 1ns / 1ps

package csp_pkg;

   // Full-scale output level and its square
   localparam logic [7:0]  FULL_SCALE    = 8'd255;
   localparam logic [15:0] FULL_SCALE_SQ = 16'd65025;

   // Pipeline depth of the shared divider and the square-root unit
   localparam int DIV_STEPS  = 16;
   localparam int SQRT_STEPS = 8;

   // Configuration register indexes
   localparam logic [1:0] CSR_RANGE_LOW  = 2'd0;
   localparam logic [1:0] CSR_RANGE_HIGH = 2'd1;
   localparam logic [1:0] CSR_CURVE_MODE = 2'd2;

   typedef enum logic [1:0] {
      MODE_LINEAR = 2'd0,
      MODE_SQRT   = 2'd1,
      MODE_QUAD   = 2'd2
   } mode_type;

   // Per-item control that travels alongside the datapath
   typedef struct packed {
      logic       valid;
      mode_type   mode;
      logic       forced;     // result is fixed, datapath is ignored
      logic [7:0] force_val;
      logic       err;
   } ctl_type;

endpackage

>>> rtl/csp_front.sv
`timescale 1ns / 1ps

module csp_front import csp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        req_valid,
   input  logic [7:0]  req_pixel_in,
   input  logic [7:0]  range_low,
   input  logic [7:0]  range_high,
   input  logic [1:0]  curve_mode,
   output ctl_type     ctl_out,
   output logic [15:0] rem_out,
   output logic [15:0] num_out,
   output logic [15:0] den_out
);

   // Stage A: range checks and offsets
   ctl_type     a_ctl_ff, a_ctl_in;
   logic [7:0]  a_d_ff, a_d_in;
   logic [7:0]  a_r_ff, a_r_in;
   // Stage B: products
   ctl_type     b_ctl_ff;
   logic [15:0] b_dd_ff, b_rr_ff, b_lin_ff;
   logic [23:0] b_sq_ff;
   logic [15:0] b_r_ff;
   // Stage C: divider operands
   ctl_type     c_ctl_ff;
   logic [23:0] c_num_in, c_num_ff;
   logic [15:0] c_den_in, c_den_ff;

   // Curve decode and range classification
   always_comb begin
      logic err, below, above;
      err   = (range_high <= range_low);
      below = (req_pixel_in < range_low);
      above = (req_pixel_in > range_high);
      a_ctl_in.valid = req_valid;
      case (curve_mode)
         MODE_SQRT: a_ctl_in.mode = MODE_SQRT;
         MODE_QUAD: a_ctl_in.mode = MODE_QUAD;
         default:   a_ctl_in.mode = MODE_LINEAR;
      endcase
      a_ctl_in.err       = err;
      a_ctl_in.forced    = err | below | above;
      a_ctl_in.force_val = (above && !err) ? FULL_SCALE : 8'd0;
      a_d_in = req_pixel_in - range_low;
      a_r_in = range_high - range_low;
   end

   // Quadratic numerator and operand select per curve
   always_comb begin
      logic [23:0] quad;
      quad = 24'(b_dd_ff) * 24'(FULL_SCALE);
      case (b_ctl_ff.mode)
         MODE_SQRT: begin
            c_num_in = b_sq_ff;
            c_den_in = b_r_ff;
         end
         MODE_QUAD: begin
            c_num_in = quad;
            c_den_in = b_rr_ff;
         end
         default: begin
            c_num_in = {8'd0, b_lin_ff};
            c_den_in = b_r_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff.valid <= 1'b0;
         b_ctl_ff.valid <= 1'b0;
         c_ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         a_ctl_ff <= a_ctl_in;
         a_d_ff   <= a_d_in;
         a_r_ff   <= a_r_in;

         b_ctl_ff <= a_ctl_ff;
         b_dd_ff  <= 16'(a_d_ff) * 16'(a_d_ff);
         b_rr_ff  <= 16'(a_r_ff) * 16'(a_r_ff);
         b_lin_ff <= 16'(a_d_ff) * 16'(FULL_SCALE);
         b_sq_ff  <= 24'(a_d_ff) * 24'(FULL_SCALE_SQ);
         b_r_ff   <= {8'd0, a_r_ff};

         c_ctl_ff <= b_ctl_ff;
         c_num_ff <= c_num_in;
         c_den_ff <= c_den_in;
      end
   end

   // Quotient fits 16 bits, so the top byte is already below the divisor
   assign ctl_out = c_ctl_ff;
   assign rem_out = {8'd0, c_num_ff[23:16]};
   assign num_out = c_num_ff[15:0];
   assign den_out = c_den_ff;

endmodule

>>> rtl/csp_div_stage.sv
`timescale 1ns / 1ps

module csp_div_stage import csp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  ctl_type     ctl_in,
   input  logic [15:0] rem_in,
   input  logic [15:0] num_in,
   input  logic [15:0] den_in,
   input  logic [15:0] quo_in,
   output ctl_type     ctl_out,
   output logic [15:0] rem_out,
   output logic [15:0] num_out,
   output logic [15:0] den_out,
   output logic [15:0] quo_out
);

   ctl_type     ctl_ff;
   logic [15:0] rem_ff, rem_nx_in;
   logic [15:0] num_ff, den_ff;
   logic [15:0] quo_ff, quo_nx_in;

   // One restoring step: bring in the next numerator bit, subtract if it fits
   always_comb begin
      logic [16:0] trial;
      trial = {rem_in, num_in[15]};
      if (trial >= {1'b0, den_in}) begin
         rem_nx_in = 16'(trial - {1'b0, den_in});
         quo_nx_in = {quo_in[14:0], 1'b1};
      end else begin
         rem_nx_in = trial[15:0];
         quo_nx_in = {quo_in[14:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
         rem_ff <= rem_nx_in;
         num_ff <= {num_in[14:0], 1'b0};
         den_ff <= den_in;
         quo_ff <= quo_nx_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign rem_out = rem_ff;
   assign num_out = num_ff;
   assign den_out = den_ff;
   assign quo_out = quo_ff;

endmodule

>>> rtl/csp_sqrt_stage.sv
`timescale 1ns / 1ps

module csp_sqrt_stage import csp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  ctl_type     ctl_in,
   input  logic [15:0] val_in,
   input  logic [9:0]  rem_in,
   input  logic [7:0]  root_in,
   input  logic [7:0]  quo_in,
   output ctl_type     ctl_out,
   output logic [15:0] val_out,
   output logic [9:0]  rem_out,
   output logic [7:0]  root_out,
   output logic [7:0]  quo_out
);

   ctl_type     ctl_ff;
   logic [15:0] val_ff;
   logic [9:0]  rem_ff, rem_nx_in;
   logic [7:0]  root_ff, root_nx_in;
   logic [7:0]  quo_ff;

   // One digit of the root: bring in two radicand bits, try {root, 01}
   always_comb begin
      logic [11:0] cur;
      logic [11:0] trial;
      cur   = {rem_in, val_in[15:14]};
      trial = {2'b00, root_in, 2'b01};
      if (cur >= trial) begin
         rem_nx_in  = 10'(cur - trial);
         root_nx_in = {root_in[6:0], 1'b1};
      end else begin
         rem_nx_in  = cur[9:0];
         root_nx_in = {root_in[6:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl_ff  <= ctl_in;
         val_ff  <= {val_in[13:0], 2'b00};
         rem_ff  <= rem_nx_in;
         root_ff <= root_nx_in;
         quo_ff  <= quo_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign val_out  = val_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign quo_out  = quo_ff;

endmodule

>>> rtl/contrast_stretch_pixel.sv
`timescale 1ns / 1ps
// Pipeline from item acceptance to rsp_valid: 3 front stages,
// 16 divider stages at one quotient bit each, 8 square-root stages, output register.
// Throughput: one item per cycle; the whole pipeline moves together and holds
// only while a result sits in the output register under rsp_stall.
// Reset (synchronous): clears all valid bits, range_low=0, range_high=255, linear curve.
module contrast_stretch_pixel import csp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_pixel_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_pixel_out,
   output logic       rsp_range_error,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   logic [7:0] range_low_ff, range_high_ff;
   logic [1:0] curve_mode_ff;
   logic       advance;

   logic       rsp_valid_ff;
   logic [7:0] rsp_pixel_out_ff, rsp_pixel_out_in;
   logic       rsp_range_error_ff;

   ctl_type     div_ctl  [0:DIV_STEPS];
   logic [15:0] div_rem  [0:DIV_STEPS];
   logic [15:0] div_num  [0:DIV_STEPS];
   logic [15:0] div_den  [0:DIV_STEPS];
   logic [15:0] div_quo  [0:DIV_STEPS];

   ctl_type     sq_ctl  [0:SQRT_STEPS];
   logic [15:0] sq_val  [0:SQRT_STEPS];
   logic [9:0]  sq_rem  [0:SQRT_STEPS];
   logic [7:0]  sq_root [0:SQRT_STEPS];
   logic [7:0]  sq_quo  [0:SQRT_STEPS];

   // Pipeline moves unless a waiting result is stalled
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= 8'd0;
         range_high_ff <= FULL_SCALE;
         curve_mode_ff <= MODE_LINEAR;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RANGE_LOW:  range_low_ff  <= csr_wdata;
            CSR_RANGE_HIGH: range_high_ff <= csr_wdata;
            CSR_CURVE_MODE: curve_mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   csp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .req_valid    (req_valid),
      .req_pixel_in (req_pixel_in),
      .range_low    (range_low_ff),
      .range_high   (range_high_ff),
      .curve_mode   (curve_mode_ff),
      .ctl_out      (div_ctl[0]),
      .rem_out      (div_rem[0]),
      .num_out      (div_num[0]),
      .den_out      (div_den[0])
   );
   assign div_quo[0] = 16'd0;

   // Shared divider, one quotient bit per stage
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      csp_div_stage u_div (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctl_in  (div_ctl[i]),
         .rem_in  (div_rem[i]),
         .num_in  (div_num[i]),
         .den_in  (div_den[i]),
         .quo_in  (div_quo[i]),
         .ctl_out (div_ctl[i+1]),
         .rem_out (div_rem[i+1]),
         .num_out (div_num[i+1]),
         .den_out (div_den[i+1]),
         .quo_out (div_quo[i+1])
      );
   end

   // Square root of the quotient; linear and quadratic results ride along
   assign sq_ctl[0]  = div_ctl[DIV_STEPS];
   assign sq_val[0]  = div_quo[DIV_STEPS];
   assign sq_rem[0]  = 10'd0;
   assign sq_root[0] = 8'd0;
   assign sq_quo[0]  = div_quo[DIV_STEPS][7:0];

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      csp_sqrt_stage u_sqrt (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .ctl_in   (sq_ctl[j]),
         .val_in   (sq_val[j]),
         .rem_in   (sq_rem[j]),
         .root_in  (sq_root[j]),
         .quo_in   (sq_quo[j]),
         .ctl_out  (sq_ctl[j+1]),
         .val_out  (sq_val[j+1]),
         .rem_out  (sq_rem[j+1]),
         .root_out (sq_root[j+1]),
         .quo_out  (sq_quo[j+1])
      );
   end

   // Final select; unused tail outputs of the last stages are dropped here
   always_comb begin
      logic [15:0] unused_bits;
      unused_bits = div_rem[DIV_STEPS] ^ div_num[DIV_STEPS] ^ div_den[DIV_STEPS]
                  ^ sq_val[SQRT_STEPS] ^ {6'd0, sq_rem[SQRT_STEPS]};
      if (sq_ctl[SQRT_STEPS].forced) begin
         rsp_pixel_out_in = sq_ctl[SQRT_STEPS].force_val;
      end else if (sq_ctl[SQRT_STEPS].mode == MODE_SQRT) begin
         rsp_pixel_out_in = sq_root[SQRT_STEPS];
      end else begin
         rsp_pixel_out_in = sq_quo[SQRT_STEPS] | (unused_bits[7:0] & 8'd0);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff       <= sq_ctl[SQRT_STEPS].valid;
         rsp_pixel_out_ff   <= rsp_pixel_out_in;
         rsp_range_error_ff <= sq_ctl[SQRT_STEPS].err;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_out   = rsp_pixel_out_ff;
   assign rsp_range_error = rsp_range_error_ff;

endmodule
